// ===== hw/rtl/ftpc_pkg.sv =====
// shared types and constants of the file transfer packet checker
package ftpc_pkg;

    localparam int NAME_BYTES       = 256;
    localparam int NAME_AW          = $clog2(NAME_BYTES);
    localparam int SIZE_FIELD_BYTES = 8;
    localparam int SEQ_MODULUS      = 255;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TYPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_TYPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TLV_COUNT  = 3'd5;

    localparam logic [3:0] ST_DATA_OK      = 4'd0;
    localparam logic [3:0] ST_START_OK     = 4'd1;
    localparam logic [3:0] ST_END_OK       = 4'd2;
    localparam logic [3:0] ST_BAD_CONTROL  = 4'd3;
    localparam logic [3:0] ST_SEQ_MISMATCH = 4'd4;
    localparam logic [3:0] ST_SHORT_HEADER = 4'd5;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd6;
    localparam logic [3:0] ST_TLV_NO_LEN   = 4'd7;
    localparam logic [3:0] ST_TLV_OVERRUN  = 4'd8;
    localparam logic [3:0] ST_TLV_UNKNOWN  = 4'd9;
    localparam logic [3:0] ST_TLV_COUNT    = 4'd10;
    localparam logic [3:0] ST_NO_NAME      = 4'd11;
    localparam logic [3:0] ST_MISMATCH     = 4'd12;
    localparam logic [3:0] ST_SIZE_LONG    = 4'd13;

    typedef enum logic [1:0] {
        FK_NONE = 2'd0, FK_CTRL = 2'd1, FK_HDR = 2'd2, FK_PAY = 2'd3
    } t_frame_kind;

    typedef enum logic [1:0] {
        TS_TYPE = 2'd0, TS_LEN = 2'd1, TS_VAL = 2'd2
    } t_tlv_step;

    typedef enum logic [1:0] {
        TK_SIZE = 2'd0, TK_NAME = 2'd1, TK_UNKNOWN = 2'd2, TK_SIZE_LONG = 2'd3
    } t_tlv_kind;

    // one queued beat: a byte and its frame end mark
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_beat;

    // result pair of one beat
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        st_valid;
        logic [3:0]  status;
        logic [63:0] cap_size;
        logic [15:0] length;
        logic [7:0]  seq;
    } t_result;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] data_code;
        logic [7:0] size_type;
        logic [7:0] name_type;
        logic [3:0] tlv_count;
    } t_cfg;

endpackage

// ===== hw/rtl/file_transfer_packet_checker.sv =====
// top level of the file transfer packet checker
// path: an input beat passes the input queue, the stage-two register and the output pair register
// throughput: one beat per cycle while the output is not stalled; a beat with payload and status takes two output beats
// the input queue holds four beats; the name store is a 256-byte memory read once per beat
// reset: i_rst_n synchronous active low, registers to defaults, waits for start
module file_transfer_packet_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte
    input  logic                            s_axis_tlast,  // frame_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // payload_byte, frame_status, size_out, payload_length, seq_seen, pad
    output logic [103:0]                    m_axis_tdata,
    output logic                            m_axis_tuser,  // item_kind
    output logic                            m_axis_tlast   // last_of_run
);
    import ftpc_pkg::*;

    t_cfg  cfg;
    t_beat beat_in, beat_q;
    logic  q_valid, take;
    logic [7:0]  pay, seq;
    logic [3:0]  status;
    logic [63:0] size;
    logic [15:0] len;

    assign beat_in = '{rx_byte: s_axis_tdata, frame_end: s_axis_tlast};

    ftpc_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_beat(beat_in),
        .o_valid(q_valid), .i_take(take), .o_beat(beat_q), .o_cfg(cfg)
    );

    ftpc_back u_back (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_valid(q_valid), .o_take(take),
        .i_beat(beat_q), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_pay(pay), .o_status(status), .o_size(size),
        .o_len(len), .o_seq(seq), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, seq, len, size, status, pay};

    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("status not last");
    a_pay_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[11:8] == 4'd0)
        else $error("payload beat with status");
endmodule

// ===== hw/rtl/ftpc_front.sv =====
// front end: configuration registers and input beat queue
module ftpc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ftpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  ftpc_pkg::t_beat                   i_beat,
    output logic                              o_valid,
    input  logic                              i_take,
    output ftpc_pkg::t_beat                   o_beat,
    output ftpc_pkg::t_cfg                    o_cfg
);
    import ftpc_pkg::*;

    t_cfg r_cfg;
    t_beat r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{start_code: 8'd2, end_code: 8'd3, data_code: 8'd1,
                       size_type: 8'd0, name_type: 8'd1, tlv_count: 4'd2};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_CODE: r_cfg.start_code <= i_cfg_data;
                CFG_END_CODE:   r_cfg.end_code   <= i_cfg_data;
                CFG_DATA_CODE:  r_cfg.data_code  <= i_cfg_data;
                CFG_SIZE_TYPE:  r_cfg.size_type  <= i_cfg_data;
                CFG_NAME_TYPE:  r_cfg.name_type  <= i_cfg_data;
                CFG_TLV_COUNT:  r_cfg.tlv_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_beat;
    end
endmodule

// ===== hw/rtl/ftpc_back.sv =====
// back end: frame parser, name store and result output stage
module ftpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftpc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_take,
    input  ftpc_pkg::t_beat     i_beat,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic                o_kind,
    output logic [7:0]          o_pay,
    output logic [3:0]          o_status,
    output logic [63:0]         o_size,
    output logic [15:0]         o_len,
    output logic [7:0]          o_seq,
    output logic                o_last
);
    import ftpc_pkg::*;

    // parser state
    logic        r_phase;
    t_frame_kind r_fk;
    logic [15:0] r_pos, r_dlen;
    logic [7:0]  r_eseq;
    t_tlv_step   r_ts;
    t_tlv_kind   r_tk;
    logic [7:0]  r_rem, r_vi, r_nlen;
    logic [3:0]  r_cnt, r_err;
    logic [63:0] r_ssize, r_wsize;
    logic        r_nseen, r_ndiff, r_nend;

    // stage two: name compare and result build
    logic        r_s2v;
    t_result     r_s2;
    logic        r_cmp;
    logic [7:0]  r_cmp_b;
    logic [7:0]  r_rd;
    logic [7:0]  name_mem [NAME_BYTES];

    // output pair register
    t_result r_out;
    logic    r_ov, r_sel;

    logic        phase_n;
    t_frame_kind fk_n;
    logic [15:0] pos_n, dlen_n;
    logic [7:0]  eseq_n, rem_n, vi_n, nlen_n;
    t_tlv_step   ts_n;
    t_tlv_kind   tk_n;
    logic [3:0]  cnt_n, err_n;
    logic [63:0] ssize_n, wsize_n;
    logic        nseen_n, ndiff_n, nend_n;
    t_result     res;
    logic        we, cmp_n;
    logic [7:0]  b;
    logic        is_start, fin, go, s2_free, out_free, ndiff_eff;
    logic [3:0]  st;

    // a pending name compare resolves into name_differs one beat late
    assign ndiff_eff = r_ndiff | (r_cmp & (r_rd != r_cmp_b));
    assign out_free  = !r_ov || (i_tready && (r_sel || !r_out.pay_valid || !r_out.st_valid));
    assign s2_free   = !r_s2v || out_free;
    assign go        = i_valid && s2_free;
    assign o_take    = go;
    assign b         = i_beat.rx_byte;
    assign is_start  = !r_phase;

    always_comb begin
        phase_n = r_phase; fk_n = r_fk; pos_n = r_pos; dlen_n = r_dlen; eseq_n = r_eseq;
        ts_n = r_ts; tk_n = r_tk; rem_n = r_rem; vi_n = r_vi; nlen_n = r_nlen;
        cnt_n = r_cnt; err_n = r_err; ssize_n = r_ssize; wsize_n = r_wsize;
        nseen_n = r_nseen; ndiff_n = ndiff_eff; nend_n = r_nend;
        res = '0; we = 1'b0; cmp_n = 1'b0; fin = 1'b0; st = ST_DATA_OK;
        case (r_fk)
            FK_NONE: begin
                err_n = '0; pos_n = '0; dlen_n = '0; ts_n = TS_TYPE; tk_n = TK_SIZE;
                rem_n = '0; vi_n = '0; cnt_n = '0; wsize_n = '1;
                nseen_n = 1'b0; ndiff_n = 1'b0; nend_n = 1'b0;
                if (is_start) begin
                    fk_n = FK_CTRL;
                    if (b != i_cfg.start_code) err_n = ST_BAD_CONTROL;
                end else if (b == i_cfg.end_code) begin
                    fk_n = FK_CTRL;
                end else begin
                    fk_n = FK_HDR;
                    pos_n = 16'd1;
                    if (b != i_cfg.data_code) err_n = ST_BAD_CONTROL;
                end
            end
            FK_CTRL: begin
                if (r_err == '0) begin
                    case (r_ts)
                        TS_TYPE: begin
                            if (b == i_cfg.size_type) tk_n = TK_SIZE;
                            else if (b == i_cfg.name_type) tk_n = TK_NAME;
                            else tk_n = TK_UNKNOWN;
                            ts_n = TS_LEN;
                        end
                        TS_LEN: begin
                            rem_n = b; vi_n = '0;
                            if (r_tk == TK_SIZE && b > 8'(SIZE_FIELD_BYTES)) tk_n = TK_SIZE_LONG;
                            if (r_tk == TK_NAME) begin
                                nseen_n = 1'b1; nend_n = 1'b0;
                                if (is_start) nlen_n = '0;
                                else ndiff_n = 1'b0;
                            end
                            if (b == '0) fin = 1'b1;
                            else ts_n = TS_VAL;
                        end
                        default: begin
                            if (r_tk == TK_SIZE && r_vi < 8'd8) begin
                                wsize_n[8*r_vi[2:0] +: 8] = b;
                            end else if (r_tk == TK_NAME && !r_nend) begin
                                if (b == '0) begin
                                    nend_n = 1'b1;
                                    if (is_start) nlen_n = r_vi;
                                    else if (r_vi != r_nlen) ndiff_n = 1'b1;
                                end else if (is_start) begin
                                    we = (32'(r_vi) < NAME_BYTES);
                                end else if (r_vi >= r_nlen) begin
                                    ndiff_n = 1'b1;
                                end else begin
                                    cmp_n = (32'(r_vi) < NAME_BYTES);
                                end
                            end
                            vi_n = r_vi + 8'd1;
                            rem_n = r_rem - 8'd1;
                            if (rem_n == '0) fin = 1'b1;
                        end
                    endcase
                    if (fin) begin
                        if (tk_n == TK_UNKNOWN) err_n = ST_TLV_UNKNOWN;
                        else if (tk_n == TK_SIZE_LONG) err_n = ST_SIZE_LONG;
                        else begin
                            if (tk_n == TK_NAME && !nend_n) begin
                                if (is_start) nlen_n = vi_n;
                                else if (vi_n != r_nlen) ndiff_n = 1'b1;
                            end
                            if (r_cnt != 4'd15) cnt_n = r_cnt + 4'd1;
                            ts_n = TS_TYPE;
                        end
                    end
                end
            end
            FK_HDR: begin
                if (r_pos == 16'd1) begin
                    if (r_err == '0 && b != r_eseq) err_n = ST_SEQ_MISMATCH;
                    pos_n = 16'd2;
                end else if (r_pos == 16'd2) begin
                    dlen_n = {b, 8'd0};
                    pos_n = 16'd3;
                end else begin
                    dlen_n = {r_dlen[15:8], b};
                    fk_n = FK_PAY;
                    pos_n = '0;
                end
            end
            default: begin
                if (r_err == '0) begin
                    if (r_pos == r_dlen) err_n = ST_LEN_MISMATCH;
                    else begin
                        res.pay_valid = 1'b1;
                        res.pay_byte = b;
                        pos_n = r_pos + 16'd1;
                    end
                end
            end
        endcase
        res.length = dlen_n;
        res.seq = r_eseq;
        if (i_beat.frame_end) begin
            res.st_valid = 1'b1;
            if (fk_n == FK_CTRL) begin
                st = err_n;
                if (st == '0 && ts_n == TS_LEN) st = ST_TLV_NO_LEN;
                if (st == '0 && ts_n == TS_VAL) st = ST_TLV_OVERRUN;
                if (st == '0 && cnt_n != i_cfg.tlv_count) st = ST_TLV_COUNT;
                if (st == '0 && !nseen_n) st = ST_NO_NAME;
                if (st == '0 && !is_start && wsize_n != r_ssize) st = ST_MISMATCH;
                // pending name compare is finished in stage two
                if (st == '0) begin
                    if (is_start) begin
                        st = ST_START_OK; phase_n = 1'b1; eseq_n = '0; ssize_n = wsize_n;
                    end else begin
                        st = ST_END_OK; phase_n = 1'b0;
                    end
                end else phase_n = 1'b0;
                res.length = '0;
                res.seq = '0;
            end else begin
                if (fk_n == FK_HDR) st = ST_SHORT_HEADER;
                else if (err_n != '0) st = err_n;
                else if (pos_n != dlen_n) st = ST_LEN_MISMATCH;
                else st = ST_DATA_OK;
                if (st == ST_DATA_OK)
                    eseq_n = (r_eseq == 8'(SEQ_MODULUS - 1)) ? 8'd0 : r_eseq + 8'd1;
                else phase_n = 1'b0;
            end
            res.status = st;
            res.cap_size = ssize_n;
            fk_n = FK_NONE;
        end
    end

    // the end-frame name check needs the last compare, done here in stage two
    logic    s2_fix;
    t_result s2_res;
    always_comb begin
        s2_res = r_s2;
        s2_fix = r_s2.st_valid && r_s2.status == ST_END_OK &&
                 (r_ndiff || (r_cmp && r_rd != r_cmp_b));
        if (s2_fix) s2_res.status = ST_MISMATCH;
    end

    always_ff @(posedge i_clk) begin
        if (we && go) name_mem[r_vi[NAME_AW-1:0]] <= b;
        if (go) r_rd <= name_mem[r_vi[NAME_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0; r_fk <= FK_NONE; r_pos <= '0; r_dlen <= '0; r_eseq <= '0;
            r_ts <= TS_TYPE; r_tk <= TK_SIZE; r_rem <= '0; r_vi <= '0; r_nlen <= '0;
            r_cnt <= '0; r_err <= '0; r_ssize <= '1; r_wsize <= '1;
            r_nseen <= 1'b0; r_ndiff <= 1'b0; r_nend <= 1'b0;
            r_s2v <= 1'b0; r_cmp <= 1'b0; r_ov <= 1'b0; r_sel <= 1'b0;
        end else begin
            if (go) begin
                r_fk <= fk_n; r_pos <= pos_n; r_dlen <= dlen_n; r_eseq <= eseq_n;
                r_ts <= ts_n; r_tk <= tk_n; r_rem <= rem_n; r_vi <= vi_n; r_nlen <= nlen_n;
                r_cnt <= cnt_n; r_err <= err_n; r_wsize <= wsize_n;
                r_nseen <= nseen_n; r_ndiff <= ndiff_n; r_nend <= nend_n;
                r_cmp <= cmp_n;
                r_phase <= phase_n; r_ssize <= ssize_n;
            end else if (s2_free) begin
                r_cmp <= 1'b0;
                r_ndiff <= ndiff_eff;
            end
            if (s2_free) r_s2v <= go && (res.pay_valid || res.st_valid);
            if (out_free) begin
                r_ov <= r_s2v;
                r_sel <= 1'b0;
            end else if (r_ov && i_tready) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && go) begin
            r_s2 <= res;
            r_cmp_b <= b;
        end
        if (out_free) r_out <= s2_res;
    end

    assign o_tvalid = r_ov;
    assign o_kind   = !(r_out.pay_valid && !r_sel);
    assign o_pay    = o_kind ? 8'd0 : r_out.pay_byte;
    assign o_status = o_kind ? r_out.status : 4'd0;
    assign o_size   = o_kind ? r_out.cap_size : 64'd0;
    assign o_len    = r_out.length;
    assign o_seq    = r_out.seq;
    assign o_last   = o_kind || !r_out.st_valid;
endmodule
